// ===== hw/rtl/wyf_pkg.sv =====
// Package for the white/yellow pixel colour filter.
// Holds the register indexes, reset values, the pipeline payload type and
// the restoring-division step shared by the back end. No dependencies.
`default_nettype none

package wyf_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WHITE_MIN = 3'd0,
    REG_HUE_MIN   = 3'd1,
    REG_HUE_MAX   = 3'd2,
    REG_SAT_MIN   = 3'd3,
    REG_VAL_MIN   = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] WhiteMinRst = 8'd200;
  localparam logic [7:0] HueMinRst   = 8'd10;
  localparam logic [7:0] HueMaxRst   = 8'd40;
  localparam logic [7:0] SatMinRst   = 8'd100;
  localparam logic [7:0] ValMinRst   = 8'd100;

  // Hue wraps at 180 half-degrees
  localparam logic [7:0] HueWrap = 8'd180;

  // Number of quotient bits, one per back-end stage
  localparam int unsigned QBits = 8;

  // Thresholds used by the back end
  typedef struct packed {
    logic [7:0] hue_min;
    logic [7:0] hue_max;
    logic [7:0] sat_min;
    logic [7:0] val_min;
  } thr_t;

  // One pixel in flight: two division lanes plus the pixel itself
  typedef struct packed {
    logic [16:0] rem_s;
    logic [8:0]  den_s;
    logic [7:0]  q_s;
    logic [16:0] rem_h;
    logic [8:0]  den_h;
    logic [7:0]  q_h;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  val;
    logic        white;
    logic        black;
    logic        gray;
  } back_t;

  // One restoring-division step on both lanes for quotient bit pos.
  function automatic back_t div_step(input back_t x, input logic [2:0] pos);
    back_t       y;
    logic [17:0] cs;
    logic [17:0] ch;
    y  = x;
    cs = {9'b0, x.den_s} << pos;
    ch = {9'b0, x.den_h} << pos;
    if ({1'b0, x.rem_s} >= cs) begin
      y.rem_s      = x.rem_s - cs[16:0];
      y.q_s[pos]   = 1'b1;
    end
    if ({1'b0, x.rem_h} >= ch) begin
      y.rem_h      = x.rem_h - ch[16:0];
      y.q_h[pos]   = 1'b1;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/white_yellow_pixel_color_filter_core.sv =====
// Top level of the white/yellow pixel colour filter: configuration
// registers, front end, queue and back end. Uses wyf_pkg, wyf_front,
// wyf_queue and wyf_back.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | in        | in_valid_i / in_stall_o   | in_blue_i, in_green_i, in_red_i
//  out     | out       | out_valid_o / out_stall_i | out_*_o, white_hit_o, yellow_hit_o
//  cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One pixel beat is taken per clock while in_stall_o is low. The path holds
// one front register, one queue slot and eight divider stages, one quotient
// bit each, plus the output register.
// Reset loads the threshold defaults and empties every stage and the queue.
// A stall on the output backs up the divider stages; the front keeps taking
// beats until the two-entry queue is full and the front register holds a beat.
`default_nettype none

module white_yellow_pixel_color_filter_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_blue_i,
  input  wire logic [7:0] in_green_i,
  input  wire logic [7:0] in_red_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_blue_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_red_o,
  output logic            white_hit_o,
  output logic            yellow_hit_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0]     white_min_q;
  wyf_pkg::thr_t  thr_q;

  logic           push;
  logic           full;
  wyf_pkg::back_t front_data;
  logic           q_valid;
  logic           pop;
  wyf_pkg::back_t q_data;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_min_q   <= wyf_pkg::WhiteMinRst;
      thr_q.hue_min <= wyf_pkg::HueMinRst;
      thr_q.hue_max <= wyf_pkg::HueMaxRst;
      thr_q.sat_min <= wyf_pkg::SatMinRst;
      thr_q.val_min <= wyf_pkg::ValMinRst;
    end else if (cfg_we_i) begin
      unique case (wyf_pkg::cfg_idx_e'(cfg_idx_i))
        wyf_pkg::REG_WHITE_MIN: white_min_q   <= cfg_data_i;
        wyf_pkg::REG_HUE_MIN:   thr_q.hue_min <= cfg_data_i;
        wyf_pkg::REG_HUE_MAX:   thr_q.hue_max <= cfg_data_i;
        wyf_pkg::REG_SAT_MIN:   thr_q.sat_min <= cfg_data_i;
        wyf_pkg::REG_VAL_MIN:   thr_q.val_min <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end
  wyf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_blue_i   (in_blue_i),
    .in_green_i  (in_green_i),
    .in_red_i    (in_red_i),
    .white_min_i (white_min_q),
    .push_o      (push),
    .full_i      (full),
    .data_o      (front_data)
  );

  // Queue between the two halves
  wyf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_data),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_data)
  );

  // Back end
  wyf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .data_i       (q_data),
    .pop_o        (pop),
    .thr_i        (thr_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_blue_o   (out_blue_o),
    .out_green_o  (out_green_o),
    .out_red_o    (out_red_o),
    .white_hit_o  (white_hit_o),
    .yellow_hit_o (yellow_hit_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/wyf_front.sv =====
// Front end of the colour filter: accepts pixel beats, runs the white test
// and sets up the saturation and hue divisions. Uses wyf_pkg.
`default_nettype none

module wyf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    in_blue_i,
  input  wire logic [7:0]    in_green_i,
  input  wire logic [7:0]    in_red_i,
  input  wire logic [7:0]    white_min_i,
  output logic               push_o,
  input  wire logic          full_i,
  output wyf_pkg::back_t     data_o
);

  logic           vld_q;
  wyf_pkg::back_t data_q;
  wyf_pkg::back_t data_d;
  logic           accept;

  logic [7:0]  v;
  logic [7:0]  mn;
  logic [7:0]  d;
  logic [11:0] u;
  logic [16:0] num_h;
  logic [16:0] num_s;

  // Largest and smallest channel
  always_comb begin
    v = in_red_i;
    if (in_green_i > v) v = in_green_i;
    if (in_blue_i > v)  v = in_blue_i;
    mn = in_red_i;
    if (in_green_i < mn) mn = in_green_i;
    if (in_blue_i < mn)  mn = in_blue_i;
    d = v - mn;
  end

  // Sector offset; the red sector is lifted by a full turn (180 half-degrees)
  // so that the numerator is never negative. Red wins ties, then green.
  always_comb begin
    if (v == in_red_i) begin
      u = 12'({d, 2'b0}) + 12'({d, 1'b0}) + 12'(in_green_i) - 12'(in_blue_i);
    end else if (v == in_green_i) begin
      u = 12'({d, 1'b0}) + 12'(in_blue_i) - 12'(in_red_i);
    end else begin
      u = 12'({d, 2'b0}) + 12'(in_red_i) - 12'(in_green_i);
    end
    num_h = 17'(u[10:0]) * 17'd60 + 17'(d);
    num_s = 17'(d) * 17'd510 + 17'(v);
  end

  // Division set-up for the back end
  always_comb begin
    data_d       = '0;
    data_d.rem_s = num_s;
    data_d.den_s = {v, 1'b0};
    data_d.rem_h = num_h;
    data_d.den_h = {d, 1'b0};
    data_d.blue  = in_blue_i;
    data_d.green = in_green_i;
    data_d.red   = in_red_i;
    data_d.val   = v;
    data_d.white = (in_blue_i >= white_min_i) && (in_green_i >= white_min_i) &&
                   (in_red_i >= white_min_i);
    data_d.black = (v == 8'd0);
    data_d.gray  = (d == 8'd0);
  end

  // The register drains into the queue whenever there is room
  assign push_o     = vld_q && !full_i;
  assign in_stall_o = vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wyf_queue.sv =====
// Two-entry queue between the front and back ends of the colour filter.
// Stores wyf_pkg::back_t beats. Uses wyf_pkg.
`default_nettype none

module wyf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wyf_pkg::back_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output wyf_pkg::back_t      data_o
);

  wyf_pkg::back_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic [1:0]     cnt_d;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!push_i && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wyf_back.sv =====
// Back end of the colour filter: pipelined restoring dividers for S and H,
// one quotient bit per stage, then the yellow test and output scaling.
// Uses wyf_pkg.
`default_nettype none

module wyf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire wyf_pkg::back_t data_i,
  output logic                pop_o,
  input  wire wyf_pkg::thr_t  thr_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          out_blue_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_red_o,
  output logic                white_hit_o,
  output logic                yellow_hit_o
);

  localparam int unsigned NSt = wyf_pkg::QBits;

  logic [NSt-1:0]  vld_q;
  wyf_pkg::back_t  st_q [NSt];
  logic [NSt:0]    rdy;

  logic            out_vld_q;
  logic [7:0]      blue_q;
  logic [7:0]      green_q;
  logic [7:0]      red_q;
  logic            white_q;
  logic            yellow_q;

  wyf_pkg::back_t  fin;
  logic [7:0]      hue;
  logic [7:0]      sat;
  logic            yellow_d;
  logic [1:0]      mult;

  // A stage may load when it is empty or its successor loads too
  assign rdy[NSt] = !out_vld_q || !out_stall_i;
  assign pop_o    = rdy[0];

  // Division stages, most significant quotient bit first
  for (genvar k = 0; k < NSt; k++) begin : g_stage
    localparam logic [2:0] Pos = 3'(NSt - 1 - k);
    wyf_pkg::back_t src;

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign src = data_i;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_q[k] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && valid_i) begin
          st_q[k] <= wyf_pkg::div_step(src, Pos);
        end
      end
    end else begin : g_rest
      assign src = st_q[k-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld_q[k-1]) begin
          st_q[k] <= wyf_pkg::div_step(src, Pos);
        end
      end
    end
  end

  // Hue wrap, black and gray pixels, then the yellow box test
  always_comb begin
    fin = st_q[NSt-1];
    if (fin.gray) begin
      hue = 8'd0;
    end else if (fin.q_h >= wyf_pkg::HueWrap) begin
      hue = fin.q_h - wyf_pkg::HueWrap;
    end else begin
      hue = fin.q_h;
    end
    sat      = fin.black ? 8'd0 : fin.q_s;
    yellow_d = (hue >= thr_i.hue_min) && (hue <= thr_i.hue_max) &&
               (sat >= thr_i.sat_min) && (fin.val >= thr_i.val_min);
    mult     = {1'b0, fin.white} + {1'b0, yellow_d};
  end

  // Channel times 0, 1 or 2, saturated at full scale
  function automatic logic [7:0] scale(input logic [7:0] c, input logic [1:0] m);
    logic [7:0] r;
    case (m)
      2'd0:    r = 8'd0;
      2'd1:    r = c;
      default: r = c[7] ? 8'hFF : {c[6:0], 1'b0};
    endcase
    return r;
  endfunction

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[NSt]) begin
      out_vld_q <= vld_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSt] && vld_q[NSt-1]) begin
      blue_q   <= scale(fin.blue, mult);
      green_q  <= scale(fin.green, mult);
      red_q    <= scale(fin.red, mult);
      white_q  <= fin.white;
      yellow_q <= yellow_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_blue_o   = blue_q;
  assign out_green_o  = green_q;
  assign out_red_o    = red_q;
  assign white_hit_o  = white_q;
  assign yellow_hit_o = yellow_q;

endmodule

`default_nettype wire

// ===== bench/wyf_filter_checker.sv =====
// Checker for the white/yellow pixel colour filter: predicts each output beat
// from the accepted input beats and the written thresholds, then compares.
// Depends on wyf_pkg for the register indexes and the threshold reset values.

module wyf_filter_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] in_blue_i,
  input  wire logic [7:0] in_green_i,
  input  wire logic [7:0] in_red_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_blue_i,
  input  wire logic [7:0] out_green_i,
  input  wire logic [7:0] out_red_i,
  input  wire logic       white_hit_i,
  input  wire logic       yellow_hit_i,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  output int unsigned     mismatches_o,
  output int unsigned     pending_o
);

  localparam int ChanMax = 255;
  localparam int HueTurn = 180;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       white;
    logic       yellow;
  } filtered_pixel_t;

  // Local copy of the threshold registers.
  logic [7:0] white_min_q;
  logic [7:0] hue_min_q;
  logic [7:0] hue_max_q;
  logic [7:0] sat_min_q;
  logic [7:0] val_min_q;

  filtered_pixel_t expected_pixels[$];
  filtered_pixel_t want;
  int unsigned     mismatch_cnt;

  // Classify one pixel against the current thresholds and scale it by the
  // number of tests it passes, saturating each channel.
  function automatic filtered_pixel_t classify_pixel(input logic [7:0] b8,
                                                     input logic [7:0] g8,
                                                     input logic [7:0] r8);
    filtered_pixel_t p;
    int b, g, r, val, lo, span, sat, hue, tilt, num, den, mult;
    b = int'(b8);
    g = int'(g8);
    r = int'(r8);
    p.white = (b8 >= white_min_q) && (g8 >= white_min_q) && (r8 >= white_min_q);

    val = r;
    if (g > val) val = g;
    if (b > val) val = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = val - lo;

    // Saturation rounded half up; a black pixel has none.
    sat = (val == 0) ? 0 : (510 * span + val) / (2 * val);

    // Hue in half degrees; red wins ties over green, green over blue.
    if (span == 0) begin
      hue = 0;
    end else begin
      if (val == r) tilt = g - b;
      else if (val == g) tilt = b - r + 2 * span;
      else tilt = r - g + 4 * span;
      num = 60 * tilt + span;
      den = 2 * span;
      hue = num / den;
      if ((num % den) != 0 && num < 0) hue = hue - 1;
      if (hue < 0) hue = hue + HueTurn;
    end

    p.yellow = (hue >= int'(hue_min_q)) && (hue <= int'(hue_max_q)) &&
               (sat >= int'(sat_min_q)) && (val >= int'(val_min_q));

    mult = int'(p.white) + int'(p.yellow);
    p.blue  = (b * mult > ChanMax) ? 8'hFF : 8'(b * mult);
    p.green = (g * mult > ChanMax) ? 8'hFF : 8'(g * mult);
    p.red   = (r * mult > ChanMax) ? 8'hFF : 8'(r * mult);
    return p;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_cnt++;
    end
  endtask

  // Watch both channels and the register port at every edge. Output beats are
  // matched before new input beats are queued, so a beat can never be
  // matched against a pixel taken in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_min_q  <= wyf_pkg::WhiteMinRst;
      hue_min_q    <= wyf_pkg::HueMinRst;
      hue_max_q    <= wyf_pkg::HueMaxRst;
      sat_min_q    <= wyf_pkg::SatMinRst;
      val_min_q    <= wyf_pkg::ValMinRst;
      expected_pixels.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("output beat with no pixel outstanding");
          mismatch_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_blue", want.blue, out_blue_i);
          check_field("out_green", want.green, out_green_i);
          check_field("out_red", want.red, out_red_i);
          check_field("white_hit", 8'(want.white), 8'(white_hit_i));
          check_field("yellow_hit", 8'(want.yellow), 8'(yellow_hit_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels.insert(expected_pixels.size(),
                               classify_pixel(in_blue_i, in_green_i, in_red_i));
      end
      // Writes to indexes beyond the last register are dropped.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wyf_pkg::REG_WHITE_MIN: white_min_q <= cfg_data_i;
          wyf_pkg::REG_HUE_MIN:   hue_min_q   <= cfg_data_i;
          wyf_pkg::REG_HUE_MAX:   hue_max_q   <= cfg_data_i;
          wyf_pkg::REG_SAT_MIN:   sat_min_q   <= cfg_data_i;
          wyf_pkg::REG_VAL_MIN:   val_min_q   <= cfg_data_i;
          default: ;
        endcase
      end
      mismatches_o <= mismatch_cnt;
      pending_o    <= expected_pixels.size();
    end
  end

endmodule

// ===== bench/tb_white_yellow_pixel_color_filter_core.sv =====
// Testbench top for the white/yellow pixel colour filter: clock, reset,
// threshold writes, pixel stimulus and output back-pressure, and the verdict.
// Depends on wyf_pkg, the filter core and wyf_filter_checker.

module tb_white_yellow_pixel_color_filter_core;

  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseItems   = 118;
  localparam int unsigned DrainCycles  = 24;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned CalmInterval = 60;
  localparam int unsigned HueTop       = 179;

  typedef struct packed {
    logic [7:0] white_min;
    logic [7:0] hue_min;
    logic [7:0] hue_max;
    logic [7:0] sat_min;
    logic [7:0] val_min;
  } thresholds_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_blue    = '0;
  logic [7:0]  in_green   = '0;
  logic [7:0]  in_red     = '0;
  logic        out_stall  = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = wyf_pkg::REG_WHITE_MIN;
  logic [7:0]  cfg_data   = '0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        white_hit;
  logic        yellow_hit;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pick;
  int unsigned pixels_sent = 0;
  logic        calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  white_yellow_pixel_color_filter_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_blue_i    (in_blue),
    .in_green_i   (in_green),
    .in_red_i     (in_red),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_blue_o   (out_blue),
    .out_green_o  (out_green),
    .out_red_o    (out_red),
    .white_hit_o  (white_hit),
    .yellow_hit_o (yellow_hit),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  wyf_filter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_blue_i    (in_blue),
    .in_green_i   (in_green),
    .in_red_i     (in_red),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_blue_i   (out_blue),
    .out_green_i  (out_green),
    .out_red_i    (out_red),
    .white_hit_i  (white_hit),
    .yellow_hit_i (yellow_hit),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Output back-pressure: short runs of stall and flow, the odd long stall,
  // and now and then a long stretch with no stall at all.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(99, 0);
      if (stall_pick < 50) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(4, 0);
      end else if (stall_pick < 85) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(3, 0);
      end else if (stall_pick < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(40, 8);
      end else begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(200, 40);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_white_yellow_pixel_color_filter_core failed");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (calm || pick < 55) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offer one pixel beat after a random gap and hold it until it is taken.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r);
    int unsigned gap;
    if (pixels_sent % CalmInterval == 0) calm = ($urandom_range(3, 0) == 0);
    pixels_sent++;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // A random pixel: plain noise, near white, yellowish, or near grey.
  task automatic send_random_pixel();
    int unsigned hi, mid, lo, base;
    case ($urandom_range(3, 0))
      0: send_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    8'($urandom_range(255, 0)));
      1: send_pixel(8'($urandom_range(255, 170)), 8'($urandom_range(255, 170)),
                    8'($urandom_range(255, 170)));
      2: begin
        hi  = $urandom_range(255, 60);
        mid = $urandom_range(hi, hi / 4);
        lo  = $urandom_range(mid / 2, 0);
        if ($urandom_range(1, 0) != 0) send_pixel(8'(lo), 8'(mid), 8'(hi));
        else send_pixel(8'(lo), 8'(hi), 8'(mid));
      end
      default: begin
        base = $urandom_range(247, 8);
        send_pixel(8'(base + $urandom_range(8, 0) - 4),
                   8'(base + $urandom_range(8, 0) - 4),
                   8'(base + $urandom_range(8, 0) - 4));
      end
    endcase
  endtask

  // Let every outstanding pixel come out, then give the pipe time to empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Write all five thresholds plus one write to an unused index, which the
  // block must drop.
  task automatic write_thresholds(input thresholds_t thr);
    write_reg(wyf_pkg::REG_WHITE_MIN, thr.white_min);
    write_reg(wyf_pkg::REG_HUE_MIN, thr.hue_min);
    write_reg(wyf_pkg::REG_HUE_MAX, thr.hue_max);
    write_reg(wyf_pkg::REG_SAT_MIN, thr.sat_min);
    write_reg(wyf_pkg::REG_VAL_MIN, thr.val_min);
    write_reg(3'($urandom_range(2 ** $bits(cfg_idx) - 1, wyf_pkg::REG_VAL_MIN + 1)),
              8'($urandom_range(255, 0)));
    cfg_we <= 1'b0;
  endtask

  // Threshold sets per phase: the extremes and four fixed sets first, then random ones.
  function automatic thresholds_t phase_thresholds(input int unsigned phase);
    thresholds_t thr;
    case (phase)
      0: thr = '{8'd0, 8'd0, 8'(HueTop), 8'd0, 8'd0};
      1: thr = '{8'd255, 8'(HueTop), 8'(HueTop), 8'd255, 8'd255};
      2: thr = '{8'd150, 8'd40, 8'd10, 8'd50, 8'd50};
      3: thr = '{8'd100, 8'd20, 8'd35, 8'd80, 8'd120};
      4: thr = '{8'd220, 8'd0, 8'd30, 8'd60, 8'd0};
      5: thr = '{8'd200, 8'd150, 8'(HueTop), 8'd0, 8'd100};
      default: begin
        thr.white_min = 8'($urandom_range(255, 0));
        thr.hue_min   = 8'($urandom_range(HueTop / 2, 0));
        thr.hue_max   = 8'($urandom_range(HueTop, thr.hue_min));
        thr.sat_min   = 8'($urandom_range(255, 0));
        thr.val_min   = 8'($urandom_range(255, 0));
      end
    endcase
    return thr;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels under the reset thresholds (b, g, r order).
    send_pixel(8'd0, 8'd0, 8'd0);         // black
    send_pixel(8'd255, 8'd255, 8'd255);   // full white
    send_pixel(8'd200, 8'd200, 8'd200);   // grey right on the white threshold
    send_pixel(8'd199, 8'd200, 8'd200);   // one channel just short of white
    send_pixel(8'd128, 8'd128, 8'd128);   // grey, not white
    send_pixel(8'd0, 8'd255, 8'd255);     // yellow, red and green tie
    send_pixel(8'd255, 8'd255, 8'd0);     // cyan, green and blue tie
    send_pixel(8'd0, 8'd0, 8'd255);       // red
    send_pixel(8'd0, 8'd255, 8'd0);       // green
    send_pixel(8'd255, 8'd0, 8'd0);       // blue
    send_pixel(8'd255, 8'd0, 8'd255);     // magenta, hue wraps
    send_pixel(8'd0, 8'd85, 8'd255);      // hue exactly at the lower bound
    send_pixel(8'd0, 8'd80, 8'd255);      // hue one below the lower bound
    send_pixel(8'd0, 8'd255, 8'd170);     // hue exactly at the upper bound
    send_pixel(8'd0, 8'd255, 8'd165);     // hue one above the upper bound
    send_pixel(8'd0, 8'd1, 8'd60);        // hue rounding a half up
    send_pixel(8'd1, 8'd0, 8'd60);        // negative half rounds up to zero
    send_pixel(8'd2, 8'd0, 8'd60);        // negative hue wraps to the top
    send_pixel(8'd155, 8'd205, 8'd255);   // saturation exactly at its minimum
    send_pixel(8'd156, 8'd205, 8'd255);   // saturation just short
    send_pixel(8'd0, 8'd100, 8'd100);     // value exactly at its minimum
    send_pixel(8'd0, 8'd99, 8'd99);       // value just short

    // Random phases, each behind a fresh set of thresholds.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      write_thresholds(phase_thresholds(phase));
      repeat (PhaseItems) send_random_pixel();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_white_yellow_pixel_color_filter_core passed");
    end else begin
      $display("tb_white_yellow_pixel_color_filter_core failed");
    end
    $finish;
  end

endmodule
